FILE: rtl/tglaa_pkg.sv
// Shared types, codes and constants of the two-group admission arbiter.
`default_nettype none
package tglaa_pkg;

  localparam int unsigned CNT_W         = 8;
  localparam int unsigned MAX_PER_GROUP = 255;
  // Waiting counters are 8 bits wide, so the cap never goes above 255.
  localparam int unsigned WAIT_CAP_INT  = (MAX_PER_GROUP > 255) ? 255 : MAX_PER_GROUP;
  localparam logic [CNT_W-1:0] WAIT_CAP       = CNT_W'(WAIT_CAP_INT);
  localparam logic [CNT_W-1:0] OCC_MAX        = '1;
  localparam logic [CNT_W-1:0] TURN_LIMIT_RST = 8'd4;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  // Event kinds
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_LEAVE  = 1'b1;

  // Fault codes
  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_EMPTY = 2'd1;
  localparam logic [1:0] FAULT_FULL  = 2'd2;

  typedef struct packed {
    logic operation;
    logic group;
  } item_t;

  typedef struct packed {
    logic [1:0]       fault;
    logic [CNT_W-1:0] waiting_one;
    logic [CNT_W-1:0] waiting_zero;
    logic             direction;
    logic [CNT_W-1:0] inside_count;
    logic             admitted_group;
    logic [CNT_W-1:0] admitted_count;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/two_group_turn_limited_admission_arbiter.sv
// Top level of the two-group turn-limited admission arbiter.
//
//  channel | direction | transfer carries
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | one event: arrival of a group, or a departure
//  out_    | master    | one result per event: admissions and new state
//  cfg_    | slave     | turn_limit write (admissions per turn)
//
// Each event passes input register -> update logic -> result register; one
// event per cycle is sustained while out_ is ready.
// The counters update in the same cycle the event leaves the input register.
// A stalled out_ holds one result while one more event waits in the input
// register. rst_n is synchronous; turn_limit resets to 4, all counters to 0.
// cfg_ready is always high; every write is accepted and registered.
`default_nettype none
module two_group_turn_limited_admission_arbiter #(
  parameter int unsigned MAX_PER_GROUP = tglaa_pkg::MAX_PER_GROUP
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [tglaa_pkg::IN_TDATA_W-1:0]  in_tdata,   // operation, group, 6'b0
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // admitted_count[7:0], admitted_group, inside_count[7:0], direction,
  // waiting_zero[7:0], waiting_one[7:0], fault[1:0], 4'b0
  output logic [tglaa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [tglaa_pkg::CNT_W-1:0] cfg_data           // turn_limit
);
  import tglaa_pkg::*;

  logic             cfg_fire;
  logic [CNT_W-1:0] limit_r;
  logic             hold_valid_r, hold_valid_nxt;
  item_t            hold_item_r;
  logic             step;
  logic             room;
  result_t          core_result;
  result_t          out_result;

  // turn_limit register
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n)        limit_r <= TURN_LIMIT_RST;
    else if (cfg_fire) limit_r <= cfg_data;
  end

  // Input register: the held event moves on whenever the result register has room.
  assign step           = hold_valid_r && room;
  assign in_tready      = !hold_valid_r || room;
  assign hold_valid_nxt = (in_tvalid && in_tready) || (hold_valid_r && !room);

  always_ff @(posedge clk) begin
    if (!rst_n) hold_valid_r <= 1'b0;
    else        hold_valid_r <= hold_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_item_r.operation <= in_tdata[0];
      hold_item_r.group     <= in_tdata[1];
    end
  end

  tglaa_core #(
    .MAX_PER_GROUP (MAX_PER_GROUP)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (hold_item_r),
    .turn_limit (limit_r),
    .result     (core_result)
  );

  tglaa_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (core_result),
    .out_ready  (out_tready),
    .room       (room),
    .out_valid  (out_tvalid),
    .out_result (out_result)
  );

  // Pack result fields, first field in the lowest bits.
  assign out_tdata = {4'b0,
                      out_result.fault,
                      out_result.waiting_one,
                      out_result.waiting_zero,
                      out_result.direction,
                      out_result.inside_count,
                      out_result.admitted_group,
                      out_result.admitted_count};

endmodule
`default_nettype wire

FILE: rtl/tglaa_core.sv
// Arbiter state registers and the single-pass event update.
`default_nettype none
module tglaa_core #(
  parameter int unsigned MAX_PER_GROUP = tglaa_pkg::MAX_PER_GROUP
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,       // consume the held item this cycle
  input  wire tglaa_pkg::item_t         item,
  input  wire logic [tglaa_pkg::CNT_W-1:0] turn_limit,
  output tglaa_pkg::result_t            result
);
  import tglaa_pkg::*;

  // Waiting counters are 8 bits wide, so the cap never goes above 255.
  localparam logic [CNT_W-1:0] WAIT_LIMIT =
    CNT_W'((MAX_PER_GROUP > 255) ? 255 : MAX_PER_GROUP);

  logic [CNT_W-1:0] wait0_r, wait0_nxt;
  logic [CNT_W-1:0] wait1_r, wait1_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] served_r, served_nxt;
  logic             dir_r, dir_nxt;
  logic             dir_set_r, dir_set_nxt;

  logic [CNT_W-1:0] eff_limit;
  logic             arr_dir;
  logic [CNT_W-1:0] arr_other;
  logic [CNT_W-1:0] arr_own;
  logic             arr_blocked;
  logic             lv_dir;
  logic [CNT_W-1:0] lv_own;
  logic [CNT_W-1:0] lv_other;
  logic [CNT_W-1:0] lv_n;
  logic [CNT_W-1:0] admitted;
  logic [1:0]       fault;

  always_comb begin
    eff_limit = (turn_limit == '0) ? CNT_W'(1) : turn_limit;

    // arrival terms
    arr_dir     = dir_set_r ? dir_r : item.group;
    arr_other   = arr_dir ? wait0_r : wait1_r;
    arr_own     = item.group ? wait1_r : wait0_r;
    arr_blocked = (item.group != arr_dir) ||
                  ((served_r >= eff_limit) && (arr_other != '0));

    // departure of the last user: pick next direction, bulk admit
    lv_dir   = (dir_r ? (wait0_r != '0) : (wait1_r != '0)) ? ~dir_r : dir_r;
    lv_own   = lv_dir ? wait1_r : wait0_r;
    lv_other = lv_dir ? wait0_r : wait1_r;
    lv_n     = ((lv_other != '0) && (lv_own > eff_limit)) ? eff_limit : lv_own;

    wait0_nxt   = wait0_r;
    wait1_nxt   = wait1_r;
    occ_nxt     = occ_r;
    served_nxt  = served_r;
    dir_nxt     = dir_r;
    dir_set_nxt = dir_set_r;
    admitted    = '0;
    fault       = FAULT_OK;

    if (item.operation == OP_ARRIVE) begin
      if (arr_blocked) begin
        if (arr_own >= WAIT_LIMIT) begin
          fault = FAULT_FULL;
        end else begin
          if (item.group) wait1_nxt = wait1_r + CNT_W'(1);
          else            wait0_nxt = wait0_r + CNT_W'(1);
          dir_nxt     = arr_dir;
          dir_set_nxt = 1'b1;
        end
      end else if (occ_r >= OCC_MAX) begin
        fault = FAULT_FULL;
      end else begin
        dir_nxt     = arr_dir;
        dir_set_nxt = 1'b1;
        occ_nxt     = occ_r + CNT_W'(1);
        if (arr_other != '0) served_nxt = served_r + CNT_W'(1);
        admitted    = CNT_W'(1);
      end
    end else begin
      if (occ_r == '0) begin
        fault = FAULT_EMPTY;
      end else if (occ_r != CNT_W'(1)) begin
        occ_nxt = occ_r - CNT_W'(1);
      end else begin
        dir_nxt    = lv_dir;
        served_nxt = (lv_other != '0) ? lv_n : '0;
        if (lv_dir) wait1_nxt = wait1_r - lv_n;
        else        wait0_nxt = wait0_r - lv_n;
        occ_nxt    = lv_n;
        admitted   = lv_n;
      end
    end

    result.admitted_count = admitted;
    result.admitted_group = dir_nxt;
    result.inside_count   = occ_nxt;
    result.direction      = dir_nxt;
    result.waiting_zero   = wait0_nxt;
    result.waiting_one    = wait1_nxt;
    result.fault          = fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait0_r   <= '0;
      wait1_r   <= '0;
      occ_r     <= '0;
      served_r  <= '0;
      dir_r     <= 1'b0;
      dir_set_r <= 1'b0;
    end else if (step) begin
      wait0_r   <= wait0_nxt;
      wait1_r   <= wait1_nxt;
      occ_r     <= occ_nxt;
      served_r  <= served_nxt;
      dir_r     <= dir_nxt;
      dir_set_r <= dir_set_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tglaa_out_stage.sv
// Result register with valid/ready toward the result channel.
`default_nettype none
module tglaa_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,      // new result enters this cycle
  input  wire tglaa_pkg::result_t  result,
  input  wire logic                out_ready,
  output logic                     room,      // register can take a result
  output logic                     out_valid,
  output tglaa_pkg::result_t       out_result
);
  import tglaa_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign room      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= result;
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;

endmodule
`default_nettype wire
